/* sv/imhq_pkg.sv */
// Shared widths, key constant, request kinds and result status codes of the indexed min-heap queue.
package imhq_pkg;

	// Fixed field widths of the stream payloads.
	localparam int KEY_W  = 31;
	localparam int VTX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int CODE_W = 2;

	// The infinite distance that a fill loads.
	localparam logic [KEY_W-1:0] KEY_INF = {KEY_W{1'b1}};

	// Request kinds.
	localparam logic [CODE_W-1:0] KIND_FILL    = 2'd0;
	localparam logic [CODE_W-1:0] KIND_DECR    = 2'd1;
	localparam logic [CODE_W-1:0] KIND_EXTRACT = 2'd2;

	// Result status codes.
	localparam logic [CODE_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [CODE_W-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [CODE_W-1:0] STAT_NOT_IN = 2'd2;

endpackage

/* sv/indexed_min_heap_queue.sv */
// Indexed binary min-heap of vertex ids with a vertex-to-slot map, one request at a time.
//
// The work of each request depends on its kind. A fill sweeps all MAX_VERTICES entries of
// the three stores, one entry a cycle. A decrease-key compares its key with one parent for
// each heap level it climbs. An extract examines one heap level at a time as it sinks, with
// a right-child compare only where a right child exists. A decrease-key on a vertex outside
// the heap ends after its range or slot check; an extract on an empty heap and an unused kind
// go straight to the result. The work is set by the single read port of each store and the
// single key comparator: every parent or child examined costs a slot read followed by a
// dependent key read, then one compare. s_axis_tready is high only while the sequencer is
// idle; the result register lets a new request enter while the previous result still
// waits on m_axis.
module indexed_min_heap_queue
	import imhq_pkg::*;
#(
	parameter int MAX_VERTICES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: vertex_count.
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	// Requests.
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,  // vertex [9:0], new_key [40:10], zero [47:41]
	input  logic [CODE_W-1:0] s_axis_tuser,  // kind [1:0]
	// Results.
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [55:0]       m_axis_tdata,  // min_vertex [9:0], min_key [40:10],
	                                         // entries_left [51:41], zero [55:52]
	output logic [CODE_W-1:0] m_axis_tuser   // status [1:0]
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int HW = AW + 1;
	localparam int CW = AW + 2;

	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_FILL  = 16'h0002,
		ST_DK_RS = 16'h0004,
		ST_DK_CK = 16'h0008,
		ST_UP_K  = 16'h0010,
		ST_UP_C  = 16'h0020,
		ST_PLACE = 16'h0040,
		ST_EX_R0 = 16'h0080,
		ST_EX_R1 = 16'h0100,
		ST_EX_R2 = 16'h0200,
		ST_EX_R3 = 16'h0400,
		ST_DN_L  = 16'h0800,
		ST_DN_LK = 16'h1000,
		ST_DN_LC = 16'h2000,
		ST_DN_RC = 16'h4000,
		ST_OUT   = 16'h8000
	} state_t;

	state_t             st_q;
	logic [CNT_W-1:0]   vcount_q;
	logic [HW-1:0]      size_q;
	logic [AW-1:0]      fill_q;
	logic [AW-1:0]      hole_q;
	logic [AW-1:0]      par_q;
	logic [AW-1:0]      pv_q;
	logic [AW-1:0]      cur_v_q;
	logic [KEY_W-1:0]   ck_q;
	logic [AW-1:0]      root_q;
	logic [KEY_W-1:0]   mk_q;
	logic [AW-1:0]      lv_q;
	logic [AW-1:0]      best_slot_q;
	logic [AW-1:0]      best_v_q;
	logic [KEY_W-1:0]   best_k_q;
	logic [CODE_W-1:0]  status_q;

	logic               m_valid_q;
	logic [CODE_W-1:0]  out_status_q;
	logic [VTX_W-1:0]   out_mv_q;
	logic [KEY_W-1:0]   out_mk_q;
	logic [CNT_W-1:0]   out_left_q;

	// Heap stores: slot to vertex, vertex to slot, vertex to key.
	logic [AW-1:0]      sv_mem [MAX_VERTICES];
	logic [AW-1:0]      vs_mem [MAX_VERTICES];
	logic [KEY_W-1:0]   vk_mem [MAX_VERTICES];

	logic               sv_we, vs_we, vk_we;
	logic [AW-1:0]      sv_wa, sv_wd, sv_ra, sv_rd_q;
	logic [AW-1:0]      vs_wa, vs_wd, vs_ra, vs_rd_q;
	logic [AW-1:0]      vk_wa, vk_ra;
	logic [KEY_W-1:0]   vk_wd, vk_rd_q;

	logic               s_acc;
	logic               out_load;
	logic               vtx_ok;
	logic [HW-1:0]      fill_size;
	logic [AW-1:0]      last_slot;
	logic               slot_ok;
	logic [AW-1:0]      i_par;
	logic [AW-1:0]      p_par;
	logic [KEY_W-1:0]   cmp_a, cmp_b;
	logic               cmp_lt;
	logic               up_lt;
	logic [CW-1:0]      l_idx, r_idx, nl_idx;
	logic               l_in, r_in, nl_in;
	logic               left_lt, right_lt;
	logic [AW-1:0]      cand_slot, cand_v;
	logic [KEY_W-1:0]   cand_k;
	logic               dec_act, dec_move;
	logic [AW-1:0]      dec_slot, dec_v;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_load      = (st_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {4'd0, out_left_q, out_mk_q, out_mv_q};

	// Request decode helpers.
	assign vtx_ok    = 32'(s_axis_tdata[VTX_W-1:0]) < MAX_VERTICES;
	assign fill_size = (32'(vcount_q) > MAX_VERTICES) ? HW'(MAX_VERTICES) : HW'(vcount_q);
	assign last_slot = AW'(size_q - HW'(1));

	// One key comparator serves every step: the climbing key against its parent, then a
	// child key against the sinking key or against the better of hole and left child.
	assign cmp_a  = (st_q == ST_UP_C) ? ck_q : vk_rd_q;
	assign cmp_b  = (st_q == ST_UP_C) ? vk_rd_q : ((st_q == ST_DN_RC) ? best_k_q : ck_q);
	assign cmp_lt = cmp_a < cmp_b;

	// Sift-up: slot check and parent addresses.
	assign slot_ok = HW'(vs_rd_q) < size_q;
	assign i_par   = (vs_rd_q - AW'(1)) >> 1;
	assign p_par   = (par_q - AW'(1)) >> 1;
	assign up_lt   = cmp_lt;

	// Sift-down: child indexes kept one bit wider than a heap size.
	assign l_idx = {1'b0, hole_q, 1'b1};
	assign r_idx = l_idx + CW'(1);
	assign l_in  = l_idx < CW'(size_q);
	assign r_in  = r_idx < CW'(size_q);

	// Sift-down: pick the smallest of hole, left child and right child; ties stay put.
	always_comb begin
		left_lt   = cmp_lt;
		cand_slot = left_lt ? AW'(l_idx) : hole_q;
		cand_v    = left_lt ? lv_q : cur_v_q;
		cand_k    = left_lt ? vk_rd_q : ck_q;
		right_lt  = cmp_lt;
		dec_act   = 1'b0;
		dec_slot  = cand_slot;
		dec_v     = cand_v;
		if (st_q == ST_DN_LC && !r_in) begin
			dec_act = 1'b1;
		end else if (st_q == ST_DN_RC) begin
			dec_act  = 1'b1;
			dec_slot = right_lt ? AW'(r_idx) : best_slot_q;
			dec_v    = right_lt ? lv_q : best_v_q;
		end
		dec_move = dec_slot != hole_q;
		nl_idx   = {1'b0, dec_slot, 1'b1};
		nl_in    = nl_idx < CW'(size_q);
	end

	// Store port control for each sequencer step.
	always_comb begin
		sv_we = 1'b0;
		sv_wa = hole_q;
		sv_wd = cur_v_q;
		sv_ra = '0;
		vs_we = 1'b0;
		vs_wa = cur_v_q;
		vs_wd = hole_q;
		vs_ra = cur_v_q;
		vk_we = 1'b0;
		vk_wa = cur_v_q;
		vk_wd = ck_q;
		vk_ra = sv_rd_q;
		case (st_q)
			ST_FILL: begin
				sv_we = 1'b1;
				sv_wa = fill_q;
				sv_wd = fill_q;
				vs_we = 1'b1;
				vs_wa = fill_q;
				vs_wd = fill_q;
				vk_we = 1'b1;
				vk_wa = fill_q;
				vk_wd = KEY_INF;
			end
			ST_DK_CK: begin
				vk_we = slot_ok;
				sv_ra = i_par;
			end
			ST_UP_C: begin
				sv_we = up_lt;
				sv_wd = pv_q;
				vs_we = up_lt;
				vs_wa = pv_q;
				sv_ra = p_par;
			end
			ST_PLACE: begin
				sv_we = 1'b1;
				vs_we = 1'b1;
			end
			ST_EX_R1: begin
				sv_ra = last_slot;
			end
			ST_EX_R3: begin
				sv_we = 1'b1;
				sv_wa = last_slot;
				sv_wd = root_q;
				vs_we = 1'b1;
				vs_wa = root_q;
				vs_wd = last_slot;
			end
			ST_DN_L: begin
				sv_ra = AW'(l_idx);
			end
			ST_DN_LK: begin
				sv_ra = AW'(r_idx);
			end
			ST_DN_LC, ST_DN_RC: begin
				if (dec_act && dec_move) begin
					sv_we = 1'b1;
					sv_wd = dec_v;
					vs_we = 1'b1;
					vs_wa = dec_v;
				end
				sv_ra = AW'(nl_idx);
			end
			default: begin
			end
		endcase
	end

	// Stores with registered read data.
	always_ff @(posedge clk) begin
		if (sv_we) sv_mem[sv_wa] <= sv_wd;
		if (vs_we) vs_mem[vs_wa] <= vs_wd;
		if (vk_we) vk_mem[vk_wa] <= vk_wd;
		sv_rd_q <= sv_mem[sv_ra];
		vs_rd_q <= vs_mem[vs_ra];
		vk_rd_q <= vk_mem[vk_ra];
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CNT_W'(1024);
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			size_q <= '0;
			fill_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (s_acc) begin
						cur_v_q  <= AW'(s_axis_tdata[VTX_W-1:0]);
						ck_q     <= s_axis_tdata[VTX_W+KEY_W-1:VTX_W];
						root_q   <= '0;
						mk_q     <= '0;
						status_q <= STAT_DONE;
						fill_q   <= '0;
						case (s_axis_tuser)
							KIND_FILL: st_q <= ST_FILL;
							KIND_DECR: begin
								if (vtx_ok) begin
									st_q <= ST_DK_RS;
								end else begin
									status_q <= STAT_NOT_IN;
									st_q     <= ST_OUT;
								end
							end
							KIND_EXTRACT: begin
								if (size_q == '0) begin
									status_q <= STAT_EMPTY;
									st_q     <= ST_OUT;
								end else begin
									st_q <= ST_EX_R0;
								end
							end
							default: st_q <= ST_OUT;
						endcase
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == AW'(MAX_VERTICES - 1)) begin
						size_q <= fill_size;
						st_q   <= ST_OUT;
					end
				end
				ST_DK_RS: st_q <= ST_DK_CK;
				ST_DK_CK: begin
					hole_q <= vs_rd_q;
					par_q  <= i_par;
					if (!slot_ok) begin
						status_q <= STAT_NOT_IN;
						st_q     <= ST_OUT;
					end else if (vs_rd_q == '0) begin
						st_q <= ST_PLACE;
					end else begin
						st_q <= ST_UP_K;
					end
				end
				ST_UP_K: begin
					pv_q <= sv_rd_q;
					st_q <= ST_UP_C;
				end
				ST_UP_C: begin
					if (up_lt) begin
						hole_q <= par_q;
						par_q  <= p_par;
						st_q   <= (par_q == '0) ? ST_PLACE : ST_UP_K;
					end else begin
						st_q <= ST_PLACE;
					end
				end
				ST_PLACE: st_q <= ST_OUT;
				ST_EX_R0: st_q <= ST_EX_R1;
				ST_EX_R1: begin
					root_q <= sv_rd_q;
					st_q   <= ST_EX_R2;
				end
				ST_EX_R2: begin
					mk_q    <= vk_rd_q;
					cur_v_q <= sv_rd_q;
					st_q    <= ST_EX_R3;
				end
				ST_EX_R3: begin
					ck_q   <= vk_rd_q;
					size_q <= size_q - HW'(1);
					hole_q <= '0;
					st_q   <= ST_DN_L;
				end
				ST_DN_L: st_q <= l_in ? ST_DN_LK : ST_PLACE;
				ST_DN_LK: begin
					lv_q <= sv_rd_q;
					st_q <= ST_DN_LC;
				end
				ST_DN_LC, ST_DN_RC: begin
					if (!dec_act) begin
						// Both children exist: hold the better of hole and left, fetch right.
						best_slot_q <= cand_slot;
						best_v_q    <= cand_v;
						best_k_q    <= cand_k;
						lv_q        <= sv_rd_q;
						st_q        <= ST_DN_RC;
					end else if (dec_move) begin
						hole_q <= dec_slot;
						st_q   <= nl_in ? ST_DN_LK : ST_PLACE;
					end else begin
						st_q <= ST_PLACE;
					end
				end
				ST_OUT: begin
					if (out_load) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= (m_valid_q && !m_axis_tready) || out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_mv_q     <= VTX_W'(root_q);
			out_mk_q     <= mk_q;
			out_left_q   <= CNT_W'(size_q);
		end
	end

	// The live heap never holds more entries than the stores.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) <= MAX_VERTICES)
		else $error("heap size above store depth");

	// An extract on an empty heap goes straight to the result with the empty status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_axis_tuser == KIND_EXTRACT && size_q == '0)
		|=> (st_q == ST_OUT && status_q == STAT_EMPTY))
		else $error("empty extract not reported");

	// While sinking, the hole stays inside the live heap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DN_LK || st_q == ST_DN_LC || st_q == ST_DN_RC) |-> HW'(hole_q) < size_q)
		else $error("sift-down hole outside heap");

	// An empty report always comes with no entries left.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STAT_EMPTY) |-> (out_left_q == '0))
		else $error("empty status with entries left");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the indexed min-heap queue: a directed table, then random rounds.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import imhq_pkg::*;

	localparam int MAX_V        = 1024;
	localparam int CLK_PERIOD   = 10;
	localparam int TOTAL_ITEMS  = 1950;
	localparam int STALL_LIMIT  = 6000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_LIMIT = 10;

	// The fourth request kind has no operation behind it.
	localparam logic [CODE_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0] status;
		logic [VTX_W-1:0]  vertex;
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  remaining;
	} outcome_t;

	// One directed step. A row with set_count writes vertex_count from key[10:0].
	typedef struct packed {
		logic [CODE_W-1:0] kind;
		logic [VTX_W-1:0]  vertex;
		logic [KEY_W-1:0]  key;
		logic              set_count;
		logic              typed;
		outcome_t          want;
	} step_row_t;

	localparam int DIRECTED_ROWS = 28;
	localparam step_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// Before any fill: empty extract and the unused kind.
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_EMPTY, 10'd0, 31'd0, 11'd0}},
		'{KIND_UNUSED, 10'd1023, KEY_INF, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd0}},
		// Four vertices: ties, a vertex never loaded, re-use after extract, a larger key.
		'{KIND_FILL, 10'd0, 31'd4, 1'b1, 1'b0, '0},
		'{KIND_FILL, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd4}},
		'{KIND_DECR, 10'd2, 31'd5, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd4}},
		'{KIND_DECR, 10'd3, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd4}},
		'{KIND_DECR, 10'd1, 31'd5, 1'b0, 1'b0, '0},
		'{KIND_DECR, 10'd9, 31'd1, 1'b0, 1'b1, '{STAT_NOT_IN, 10'd0, 31'd0, 11'd4}},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd3, 31'd0, 11'd3}},
		'{KIND_DECR, 10'd3, 31'd7, 1'b0, 1'b1, '{STAT_NOT_IN, 10'd0, 31'd0, 11'd3}},
		'{KIND_DECR, 10'd1, 31'd10, 1'b0, 1'b0, '0},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b0, '0},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b0, '0},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b0, '0},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_EMPTY, 10'd0, 31'd0, 11'd0}},
		// A count of zero gives an empty heap.
		'{KIND_FILL, 10'd0, 31'd0, 1'b1, 1'b0, '0},
		'{KIND_FILL, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd0}},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_EMPTY, 10'd0, 31'd0, 11'd0}},
		'{KIND_DECR, 10'd0, 31'd3, 1'b0, 1'b1, '{STAT_NOT_IN, 10'd0, 31'd0, 11'd0}},
		// An oversized count saturates to the full heap.
		'{KIND_FILL, 10'd0, 31'd2047, 1'b1, 1'b0, '0},
		'{KIND_FILL, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd1024}},
		'{KIND_DECR, 10'd1023, 31'd0, 1'b0, 1'b0, '0},
		'{KIND_DECR, 10'd0, KEY_INF, 1'b0, 1'b0, '0},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd1023, 31'd0, 11'd1023}},
		'{KIND_UNUSED, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd1023}},
		// Smallest count: the only vertex comes out with the infinite key.
		'{KIND_FILL, 10'd0, 31'd1, 1'b1, 1'b0, '0},
		'{KIND_FILL, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd0, 31'd0, 11'd1}},
		'{KIND_EXTRACT, 10'd0, 31'd0, 1'b0, 1'b1, '{STAT_DONE, 10'd0, KEY_INF, 11'd0}}
	};

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_we        = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata     = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata  = '0;  // vertex [9:0], new_key [40:10], zero [47:41]
	logic [CODE_W-1:0] s_axis_tuser  = '0;  // kind [1:0]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [55:0]       m_axis_tdata;        // min_vertex [9:0], min_key [40:10],
	                                        // entries_left [51:41], zero [55:52]
	logic [CODE_W-1:0] m_axis_tuser;        // status [1:0]

	indexed_min_heap_queue #(
		.MAX_VERTICES(MAX_V)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Heap mirror: slot to vertex, vertex to slot, keys, live size and the fill count.
	logic [VTX_W-1:0] heap_vtx [MAX_V];
	logic [VTX_W-1:0] vtx_slot [MAX_V];
	logic [KEY_W-1:0] vtx_key  [MAX_V];
	int unsigned      heap_len;
	int unsigned      fill_count;

	outcome_t pending_results [$];
	int       failures     = 0;
	int       issued       = 0;
	int       send_gap_pct = 0;
	int       recv_gap_pct = 0;
	int       burst_asked  = 0;
	int       burst_done   = 0;
	int       idle_cycles  = 0;

	function automatic logic [KEY_W-1:0] slot_key(int unsigned s);
		return vtx_key[heap_vtx[s]];
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [VTX_W-1:0] va;
		logic [VTX_W-1:0] vb;
		va = heap_vtx[a];
		vb = heap_vtx[b];
		heap_vtx[a] = vb;
		heap_vtx[b] = va;
		vtx_slot[vb] = VTX_W'(a);
		vtx_slot[va] = VTX_W'(b);
	endfunction

	// Only a strictly smaller key moves up.
	function automatic void sift_up(int unsigned i);
		int unsigned p;
		while (i != 0) begin
			p = (i - 1) / 2;
			if (!(slot_key(i) < slot_key(p)))
				return;
			swap_slots(i, p);
			i = p;
		end
	endfunction

	function automatic void sift_down(int unsigned i);
		int unsigned best;
		int unsigned l;
		int unsigned r;
		forever begin
			best = i;
			l = 2 * i + 1;
			r = 2 * i + 2;
			if (l < heap_len && slot_key(l) < slot_key(best))
				best = l;
			if (r < heap_len && slot_key(r) < slot_key(best))
				best = r;
			if (best == i)
				return;
			swap_slots(best, i);
			i = best;
		end
	endfunction

	// Applies one request to the mirror and returns the result it must give.
	function automatic outcome_t apply_request(logic [CODE_W-1:0] kind, logic [VTX_W-1:0] v,
	                                           logic [KEY_W-1:0] key);
		outcome_t    res;
		int          i;
		logic [VTX_W-1:0] top;
		res = '0;
		res.status = STAT_DONE;
		case (kind)
			KIND_FILL: begin
				for (i = 0; i < MAX_V; i++) begin
					heap_vtx[i] = VTX_W'(i);
					vtx_slot[i] = VTX_W'(i);
					vtx_key[i]  = KEY_INF;
				end
				heap_len = (fill_count > MAX_V) ? MAX_V : fill_count;
			end
			KIND_DECR: begin
				if (vtx_slot[v] < heap_len) begin
					vtx_key[v] = key;
					sift_up(vtx_slot[v]);
				end else begin
					res.status = STAT_NOT_IN;
				end
			end
			KIND_EXTRACT: begin
				if (heap_len == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					top = heap_vtx[0];
					res.vertex = top;
					res.key = vtx_key[top];
					swap_slots(0, heap_len - 1);
					heap_len = heap_len - 1;
					sift_down(0);
				end
			end
			default: begin
			end
		endcase
		res.remaining = CNT_W'(heap_len);
		return res;
	endfunction

	// Small keys for ties, wide keys, the infinite key, zero, and a key above the current one.
	function automatic logic [KEY_W-1:0] pick_key(logic [VTX_W-1:0] v);
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return KEY_W'($urandom_range(15));
		if (roll < 60)
			return KEY_W'($urandom_range(1000));
		if (roll < 80)
			return KEY_W'($urandom);
		if (roll < 88)
			return KEY_INF;
		if (roll < 93)
			return '0;
		if (vtx_key[v] > KEY_INF - 50)
			return KEY_INF;
		return vtx_key[v] + KEY_W'($urandom_range(50, 1));
	endfunction

	// Mostly small heaps; now and then full, oversized or empty ones.
	function automatic logic [CNT_W-1:0] pick_count();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return CNT_W'($urandom_range(24, 1));
		if (roll < 82)
			return CNT_W'($urandom_range(200, 25));
		if (roll < 87)
			return CNT_W'(MAX_V);
		if (roll < 91)
			return CNT_W'($urandom_range(2047, 1025));
		if (roll < 94)
			return '0;
		return CNT_W'($urandom_range(1023, 201));
	endfunction

	// Offers one request, waits for its handshake and records the result it must give.
	task automatic send_request(logic [CODE_W-1:0] kind, logic [VTX_W-1:0] v,
	                            logic [KEY_W-1:0] key, logic typed, outcome_t want);
		outcome_t res;
		if (issued < TOTAL_ITEMS / 3) begin
			send_gap_pct = 26;
			recv_gap_pct = 52;
		end else if (issued < 2 * TOTAL_ITEMS / 3) begin
			send_gap_pct = 52;
			recv_gap_pct = 26;
		end else begin
			send_gap_pct = 0;
			recv_gap_pct = 0;
		end
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, key, v};
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		res = apply_request(kind, v, key);
		pending_results.push_back(typed ? want : res);
		issued++;
	endtask

	// Stops offering and waits until every result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		fill_count = value;
	endtask

	// Result side: check each accepted result, then choose the next ready level.
	initial begin
		outcome_t got;
		outcome_t want;
		int       hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.status    = m_axis_tuser;
				got.vertex    = m_axis_tdata[9:0];
				got.key       = m_axis_tdata[40:10];
				got.remaining = m_axis_tdata[51:41];
				if (pending_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("%0t: result with no request pending: status %0d vertex %0d key %0d left %0d",
						         $realtime, got.status, got.vertex, got.key, got.remaining);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.vertex !== want.vertex ||
					    got.key !== want.key || got.remaining !== want.remaining) begin
						failures++;
						if (failures <= REPORT_LIMIT)
							$display("%0t: mismatch: expected status %0d vertex %0d key %0d left %0d, got status %0d vertex %0d key %0d left %0d",
							         $realtime, want.status, want.vertex, want.key, want.remaining,
							         got.status, got.vertex, got.key, got.remaining);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (burst_done != burst_asked) begin
				burst_done++;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus: reset, directed table, random rounds, then the final verdict.
	initial begin
		int               r;
		int               round_len;
		int               roll;
		int               j;
		logic [VTX_W-1:0] v;
		heap_len   = 0;
		fill_count = MAX_V;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].set_count) begin
				drain_results();
				write_count(DIRECTED[r].key[CNT_W-1:0]);
			end else begin
				send_request(DIRECTED[r].kind, DIRECTED[r].vertex, DIRECTED[r].key,
				             DIRECTED[r].typed, DIRECTED[r].want);
			end
		end

		// Each round: new count, a fill, then mostly decrease-key on live vertices and extracts.
		while (issued < TOTAL_ITEMS) begin
			drain_results();
			write_count(pick_count());
			send_request(KIND_FILL, VTX_W'($urandom), KEY_W'($urandom), 1'b0, '0);
			round_len = $urandom_range(60, 8);
			for (j = 0; j < round_len && issued < TOTAL_ITEMS; j++) begin
				// Long result-side hold-offs while requests keep coming.
				if (issued >= 300 && burst_asked == 0)
					burst_asked++;
				if (issued >= 1400 && burst_asked == 1)
					burst_asked++;
				roll = $urandom_range(99);
				if (heap_len == 0 && roll < 70)
					break;
				if (roll < 48) begin
					if (heap_len > 0)
						v = heap_vtx[$urandom_range(heap_len - 1)];
					else
						v = VTX_W'($urandom);
					send_request(KIND_DECR, v, pick_key(v), 1'b0, '0);
				end else if (roll < 56) begin
					v = VTX_W'($urandom);
					send_request(KIND_DECR, v, pick_key(v), 1'b0, '0);
				end else if (roll < 93) begin
					send_request(KIND_EXTRACT, VTX_W'($urandom), KEY_W'($urandom), 1'b0, '0);
				end else if (roll < 97) begin
					send_request(KIND_UNUSED, VTX_W'($urandom), KEY_W'($urandom), 1'b0, '0);
				end else begin
					send_request(KIND_FILL, VTX_W'($urandom), KEY_W'($urandom), 1'b0, '0);
				end
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		failures += pending_results.size();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* indexed_min_heap_queue.f */
sv/imhq_pkg.sv
sv/indexed_min_heap_queue.sv
test/testbench.sv
